/* hw/rtl/message_frame_checker_unit_defines.svh */
// Assertion macros for the frame checker's port-level assertion checker.
`ifndef MESSAGE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define MESSAGE_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define MFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define MFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset.
`define MFC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mfc_pkg.sv */
// Shared constants, types and the CRC byte update for the frame checker.
package mfc_pkg;

    localparam int LEN_W = 10;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [LEN_W-1:0] MIN_LEN = 10'd9;
    localparam logic [LEN_W-1:0] LAST_HDR_IDX = 10'd5;
    localparam logic [LEN_W-1:0] LEN_IDX = 10'd6;

    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       priority_res;
        logic [1:0]       confirm_mode;
        logic [2:0]       sender_high;
        logic [3:0]       sender_middle;
        logic [4:0]       sender_low;
        logic [2:0]       recipient_high;
        logic [3:0]       recipient_middle;
        logic [4:0]       recipient_low;
        logic [5:0]       msg_kind;
        logic [LEN_W-1:0] frame_length;
        logic [1:0]       status;
    } t_result;

    // MSB-first CRC-16 update over one byte, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mfc_in_stage.sv */
// Input register of the frame checker.
module mfc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mfc_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_take,
    output logic              o_valid,
    output mfc_pkg::t_in_item o_item
);

    logic              r_valid;
    mfc_pkg::t_in_item r_item;

    // Slot frees when empty or when its item moves on this cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hw/rtl/mfc_frame_ctrl.sv */
// Frame state, header capture, CRC update and result formation.
module mfc_frame_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mfc_pkg::t_in_item i_item,
    input  logic              i_crc_en,
    output logic              o_emit,
    output mfc_pkg::t_result  o_result
);

    logic                     r_active, n_active;
    logic [mfc_pkg::LEN_W-1:0] r_index, n_index;
    logic [15:0]              r_crc, n_crc;
    logic [7:0]               r_hdr [0:5];
    logic [7:0]               n_hdr [0:5];
    logic [mfc_pkg::LEN_W-1:0] r_len, n_len;
    logic [7:0]               r_rx_hi, n_rx_hi;

    logic                     active;
    logic [mfc_pkg::LEN_W-1:0] idx;
    logic [mfc_pkg::LEN_W:0]  idx_p2;
    logic [15:0]              crc_cur;
    logic [7:0]               crc_in;
    logic [15:0]              crc_nxt;
    logic [1:0]               status;

    always_comb begin
        active  = i_item.frame_start || r_active;
        idx     = i_item.frame_start ? '0 : r_index;
        crc_cur = i_item.frame_start ? mfc_pkg::CRC_INIT : r_crc;
        idx_p2  = {1'b0, idx} + (mfc_pkg::LEN_W+1)'(2);

        n_active = r_active;
        n_index  = r_index;
        n_crc    = r_crc;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_rx_hi  = r_rx_hi;
        o_emit   = 1'b0;
        status   = mfc_pkg::STATUS_GOOD;
        crc_in   = i_item.data_byte;

        // Augment steps: the received CRC bytes are replaced by zeros.
        if (idx > mfc_pkg::LEN_IDX && idx_p2 >= {1'b0, r_len}) begin
            crc_in = 8'h00;
        end
        crc_nxt = mfc_pkg::crc_byte(crc_cur, crc_in);

        if (active) begin
            n_active = 1'b1;
            n_index  = idx + mfc_pkg::LEN_W'(1);
            if (idx <= mfc_pkg::LAST_HDR_IDX) begin
                n_crc = crc_nxt;
                n_hdr[idx[2:0]] = i_item.data_byte;
            end else if (idx == mfc_pkg::LEN_IDX) begin
                n_crc = crc_nxt;
                n_len = {r_hdr[5][1:0], i_item.data_byte};
                if (n_len < mfc_pkg::MIN_LEN) begin
                    n_active = 1'b0;
                    o_emit   = 1'b1;
                    status   = mfc_pkg::STATUS_SHORT;
                end
            end else if (idx_p2 < {1'b0, r_len}) begin
                n_crc = crc_nxt;
            end else if (idx_p2 == {1'b0, r_len}) begin
                // first augment byte folded in now
                n_rx_hi = i_item.data_byte;
                n_crc   = crc_nxt;
            end else begin
                n_active = 1'b0;
                o_emit   = 1'b1;
                if (i_crc_en && {r_rx_hi, i_item.data_byte} != crc_nxt) begin
                    status = mfc_pkg::STATUS_CRC_BAD;
                end
            end
        end
    end

    always_comb begin
        o_result.priority_res     = r_hdr[1][7:6];
        o_result.confirm_mode     = r_hdr[1][5:4];
        o_result.sender_high      = r_hdr[2][7:5];
        o_result.sender_middle    = r_hdr[2][4:1];
        o_result.sender_low       = {r_hdr[2][0], r_hdr[3][7:4]};
        o_result.recipient_high   = r_hdr[3][3:1];
        o_result.recipient_middle = {r_hdr[3][0], r_hdr[4][7:5]};
        o_result.recipient_low    = r_hdr[4][4:0];
        o_result.msg_kind         = r_hdr[5][7:2];
        o_result.frame_length     = n_len;
        o_result.status           = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_index  <= '0;
            r_crc    <= mfc_pkg::CRC_INIT;
        end else if (i_step) begin
            r_active <= n_active;
            r_index  <= n_index;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_rx_hi <= n_rx_hi;
        end
    end

endmodule

/* hw/rtl/message_frame_checker_unit.sv */
// Top level of the byte-serial message frame checker (CRC-16, poly 0x1021).
// Processes one byte per cycle while the result register is free and registers any result.
// The single-pass CRC/field logic is the only work stage.
// o_in_ready drops only while the input register is full and the result register stalls.
// Reset (synchronous, i_rst_n low): no frame in progress, CRC 0xFFFF, registers empty,
// CRC check enabled.
module message_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    // configuration: crc_check_enable
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_priority_res,
    output logic [1:0]  o_confirm_mode,
    output logic [2:0]  o_sender_high,
    output logic [3:0]  o_sender_middle,
    output logic [4:0]  o_sender_low,
    output logic [2:0]  o_recipient_high,
    output logic [3:0]  o_recipient_middle,
    output logic [4:0]  o_recipient_low,
    output logic [5:0]  o_msg_kind,
    output logic [9:0]  o_frame_length,
    output logic [1:0]  o_status
);

    // Check-enable register; 1 compares received and computed CRC.
    logic r_crc_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_crc_en <= i_cfg_wdata;
        end
    end

    // Input register: holds one byte ahead of the processing stage.
    mfc_pkg::t_in_item in_item;
    mfc_pkg::t_in_item stage_item;
    logic              stage_valid;
    logic              out_free;
    logic              step;

    assign in_item.data_byte   = i_data_byte;
    assign in_item.frame_start = i_frame_start;

    // Result register can load when empty or drained this cycle.
    assign out_free = !o_out_valid || i_out_ready;
    // A buffered byte is processed exactly when its result has somewhere to go.
    assign step = stage_valid && out_free;

    mfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_ready (o_in_ready),
        .i_take  (out_free),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // Frame state and per-byte work: header capture, length, CRC, status.
    logic             emit;
    mfc_pkg::t_result result;

    mfc_frame_ctrl u_frame_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (stage_item),
        .i_crc_en (r_crc_en),
        .o_emit   (emit),
        .o_result (result)
    );

    // Result register: decouples the downstream stall from the byte stream.
    logic             r_out_valid;
    mfc_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_priority_res     = r_out.priority_res;
    assign o_confirm_mode     = r_out.confirm_mode;
    assign o_sender_high      = r_out.sender_high;
    assign o_sender_middle    = r_out.sender_middle;
    assign o_sender_low       = r_out.sender_low;
    assign o_recipient_high   = r_out.recipient_high;
    assign o_recipient_middle = r_out.recipient_middle;
    assign o_recipient_low    = r_out.recipient_low;
    assign o_msg_kind         = r_out.msg_kind;
    assign o_frame_length     = r_out.frame_length;
    assign o_status           = r_out.status;

endmodule

/* hw/rtl/mfc_checker.sv */
// Port-level assertion checker for the frame checker, with its bind.
`include "message_frame_checker_unit_defines.svh"

module mfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [9:0] o_frame_length,
    input logic [1:0] o_status
);

    `MFC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_frame_length),
        "stalled result changed")
    `MFC_ASSERT_NOW(a_short_len, o_out_valid && o_status == mfc_pkg::STATUS_SHORT,
        o_frame_length < mfc_pkg::MIN_LEN, "short status with long length")
    `MFC_ASSERT_NOW(a_full_len, o_out_valid && o_status != mfc_pkg::STATUS_SHORT,
        o_frame_length >= mfc_pkg::MIN_LEN && (o_status == mfc_pkg::STATUS_GOOD ||
        o_status == mfc_pkg::STATUS_CRC_BAD), "full-frame result with bad length or status")
    `MFC_ASSERT_NOW(a_ready_idle, !o_out_valid, o_in_ready,
        "input blocked with empty result register")
    `MFC_ASSERT_NEXT_ALWAYS(a_reset_clear, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind message_frame_checker_unit mfc_checker u_mfc_checker (.*);
